// ===== sv/dwf_pkg.sv =====
package dwf_pkg;

  // Field widths fixed by the port list
  localparam int COORD_W  = 9;
  localparam int HALF_W   = 8;
  localparam int COLOUR_W = 16;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W    = 2 * COORD_W + 1;

  // Default coordinate width handed to the top level
  localparam int COORD_BITS = 9;

  // Register reset values
  localparam logic [COORD_W-1:0] COLUMN_LIMIT_RESET = COORD_W'(240);
  localparam logic [COORD_W-1:0] ROW_LIMIT_RESET    = COORD_W'(320);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT    = CFG_IDX_W'(1);

  // Request codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Request after classification, queued between front and back
  typedef struct packed {
    logic                cmd;
    logic [COORD_W-1:0]  col_lo;
    logic [COORD_W-1:0]  col_hi;
    logic [COORD_W-1:0]  row_lo;
    logic [COORD_W-1:0]  row_hi;
    logic [COLOUR_W-1:0] colour;
  } work_t;

  // One output byte with its flags
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_data;
    logic              last;
  } res_t;

endpackage

// ===== sv/dwf_fifo.sv =====
module dwf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/dwf_front.sv =====
module dwf_front #(
  parameter int COORD_BITS = dwf_pkg::COORD_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dwf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dwf_pkg::COORD_W-1:0]      cfg_data,
  input  logic                             push,
  input  logic                             cmd,
  input  logic [dwf_pkg::COORD_W-1:0]      centre_x,
  input  logic [dwf_pkg::COORD_W-1:0]      centre_y,
  input  logic [dwf_pkg::HALF_W-1:0]       half_size,
  input  logic [dwf_pkg::COLOUR_W-1:0]     fill_colour,
  input  logic                             q_full,
  output logic                             q_wr,
  output dwf_pkg::work_t                   q_data
);

  import dwf_pkg::*;

  // coordinates are kept to the narrower of the parameter and the port
  localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;

  logic [COORD_W-1:0]   column_limit;
  logic [COORD_W-1:0]   row_limit;
  logic [2*COORD_W-1:0] col_bounds;
  logic [2*COORD_W-1:0] row_bounds;

  // clamp centre to limit, then clip [c-half, c+half] to [0, limit]
  function automatic logic [2*COORD_W-1:0] clip_axis(
    input logic [COORD_W-1:0] centre,
    input logic [HALF_W-1:0]  half,
    input logic [COORD_W-1:0] limit
  );
    logic [CW-1:0] c;
    logic [CW-1:0] lim;
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
    logic [CW:0]   top;
    c   = centre[CW-1:0];
    lim = limit[CW-1:0];
    if (c > lim) begin
      c = lim;
    end
    lo  = (c >= CW'(half)) ? (c - CW'(half)) : '0;
    top = {1'b0, c} + (CW + 1)'(half);
    hi  = (top <= {1'b0, lim}) ? top[CW-1:0] : lim;
    return {COORD_W'(hi), COORD_W'(lo)};
  endfunction

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_limit <= COLUMN_LIMIT_RESET;
      row_limit    <= ROW_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COLUMN_LIMIT: column_limit <= cfg_data;
        REG_ROW_LIMIT:    row_limit    <= cfg_data;
        default: ;
      endcase
    end
  end

  // window clipping on the way into the queue
  assign col_bounds = clip_axis(centre_x, half_size, column_limit);
  assign row_bounds = clip_axis(centre_y, half_size, row_limit);

  assign q_wr = push && !q_full;

  always_comb begin
    q_data.cmd    = cmd;
    q_data.col_lo = col_bounds[COORD_W-1:0];
    q_data.col_hi = col_bounds[2*COORD_W-1:COORD_W];
    q_data.row_lo = row_bounds[COORD_W-1:0];
    q_data.row_hi = row_bounds[2*COORD_W-1:COORD_W];
    q_data.colour = fill_colour;
  end

endmodule

// ===== sv/dwf_back.sv =====
module dwf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  dwf_pkg::work_t  q_data,
  output logic            q_rd,
  input  logic            out_full,
  output logic            out_wr,
  output dwf_pkg::res_t   out_data
);

  import dwf_pkg::*;

  // header positions
  localparam logic [3:0] HDR_COLUMN_SET = 4'd0;
  localparam logic [3:0] HDR_COL_LO_H   = 4'd1;
  localparam logic [3:0] HDR_COL_LO_L   = 4'd2;
  localparam logic [3:0] HDR_COL_HI_H   = 4'd3;
  localparam logic [3:0] HDR_COL_HI_L   = 4'd4;
  localparam logic [3:0] HDR_ROW_SET    = 4'd5;
  localparam logic [3:0] HDR_ROW_LO_H   = 4'd6;
  localparam logic [3:0] HDR_ROW_LO_L   = 4'd7;
  localparam logic [3:0] HDR_ROW_HI_H   = 4'd8;
  localparam logic [3:0] HDR_ROW_HI_L   = 4'd9;
  localparam logic [3:0] HDR_RAM_WRITE  = 4'd10;
  localparam logic [3:0] PIXEL_PHASE    = 4'd11;

  localparam logic [BYTE_W-1:0] OP_COLUMN_SET = 8'h2A;
  localparam logic [BYTE_W-1:0] OP_ROW_SET    = 8'h2B;
  localparam logic [BYTE_W-1:0] OP_RAM_WRITE  = 8'h2C;

  logic                busy;
  logic [3:0]          header_index;
  logic [COORD_W-1:0]  col_lo;
  logic [COORD_W-1:0]  col_hi;
  logic [COORD_W-1:0]  row_lo;
  logic [COORD_W-1:0]  row_hi;
  logic [PIX_W-1:0]    pixels_left;
  logic [COLOUR_W-1:0] colour_latch;
  logic                low_half_next;

  logic                take;
  logic                is_start;
  logic [COORD_W:0]    width_q;
  logic [COORD_W:0]    height_q;
  logic [PIX_W-1:0]    pixels_dec;
  logic [BYTE_W-1:0]   hdr_byte;
  logic                hdr_is_data;

  // a start always drains; an advance waits for output space
  assign is_start = (q_data.cmd == CMD_START);
  assign take     = !q_empty && (is_start || !out_full);
  assign q_rd     = take;

  // inclusive extents of the new window
  assign width_q  = {1'b0, q_data.col_hi} - {1'b0, q_data.col_lo} + 1'b1;
  assign height_q = {1'b0, q_data.row_hi} - {1'b0, q_data.row_lo} + 1'b1;

  assign pixels_dec = (pixels_left != '0) ? pixels_left - 1'b1 : '0;

  // header byte select
  always_comb begin
    hdr_is_data = 1'b1;
    case (header_index)
      HDR_COLUMN_SET: begin
        hdr_byte    = OP_COLUMN_SET;
        hdr_is_data = 1'b0;
      end
      HDR_COL_LO_H:  hdr_byte = BYTE_W'(16'(col_lo) >> 8);
      HDR_COL_LO_L:  hdr_byte = col_lo[BYTE_W-1:0];
      HDR_COL_HI_H:  hdr_byte = BYTE_W'(16'(col_hi) >> 8);
      HDR_COL_HI_L:  hdr_byte = col_hi[BYTE_W-1:0];
      HDR_ROW_SET: begin
        hdr_byte    = OP_ROW_SET;
        hdr_is_data = 1'b0;
      end
      HDR_ROW_LO_H:  hdr_byte = BYTE_W'(16'(row_lo) >> 8);
      HDR_ROW_LO_L:  hdr_byte = row_lo[BYTE_W-1:0];
      HDR_ROW_HI_H:  hdr_byte = BYTE_W'(16'(row_hi) >> 8);
      HDR_ROW_HI_L:  hdr_byte = row_hi[BYTE_W-1:0];
      HDR_RAM_WRITE: begin
        hdr_byte    = OP_RAM_WRITE;
        hdr_is_data = 1'b0;
      end
      default:       hdr_byte = '0;
    endcase
  end

  // output byte for the current position
  always_comb begin
    out_wr            = take && !is_start && busy;
    out_data.is_data  = 1'b1;
    out_data.last     = 1'b0;
    if (header_index < PIXEL_PHASE) begin
      out_data.out_byte = hdr_byte;
      out_data.is_data  = hdr_is_data;
    end else if (!low_half_next) begin
      out_data.out_byte = colour_latch[15:8];
    end else begin
      out_data.out_byte = colour_latch[7:0];
      out_data.last     = (pixels_dec == '0);
    end
  end

  // window state, no reset needed on payload
  always_ff @(posedge clk) begin
    if (take && is_start) begin
      col_lo       <= q_data.col_lo;
      col_hi       <= q_data.col_hi;
      row_lo       <= q_data.row_lo;
      row_hi       <= q_data.row_hi;
      colour_latch <= q_data.colour;
    end
  end

  // sequencing state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      header_index  <= HDR_COLUMN_SET;
      pixels_left   <= '0;
      low_half_next <= 1'b0;
    end else if (take && is_start) begin
      busy          <= 1'b1;
      header_index  <= HDR_COLUMN_SET;
      pixels_left   <= PIX_W'(width_q) * PIX_W'(height_q);
      low_half_next <= 1'b0;
    end else if (out_wr) begin
      if (header_index < PIXEL_PHASE) begin
        header_index <= header_index + 1'b1;
      end else if (!low_half_next) begin
        low_half_next <= 1'b1;
      end else begin
        low_half_next <= 1'b0;
        pixels_left   <= pixels_dec;
        if (pixels_dec == '0) begin
          busy         <= 1'b0;
          header_index <= HDR_COLUMN_SET;
        end
      end
    end
  end

endmodule

// ===== sv/display_window_fill_sequencer.sv =====
// Window fill byte sequencer for a DCS style display link.
// Input queue (push/full): cmd 0 starts a fill with centre, half size and
// colour; cmd 1 asks for the next byte. A start gives no byte; an advance
// while no fill is running is dropped.
// Output queue (empty/pop): out_byte, is_data, last. Bytes come in order:
// 0x2A and four column bytes, 0x2B and four row bytes, 0x2C, then the
// colour high and low byte for each pixel; last marks the final low byte.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): column_limit
// and row_limit, always ready, used at the next start.
// Flow: a request is clipped on entry and written to the request queue; the
// back writes its byte into the output queue in the same cycle it reads the
// request from the request queue, and the byte can then be popped. One
// request per cycle is taken while the two-entry queues between front, back
// and output have room; a stall on either side holds the flow once they fill.
// Stalls: when pop stays low the output queue fills, the back stops
// draining advances, and full rises once the front queue is full.
// Reset: limits return to 240 and 320, both queues empty, no fill running.
module display_window_fill_sequencer #(
  parameter int COORD_BITS = dwf_pkg::COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dwf_pkg::COORD_W-1:0]   cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic                          cmd,
  input  logic [dwf_pkg::COORD_W-1:0]   centre_x,
  input  logic [dwf_pkg::COORD_W-1:0]   centre_y,
  input  logic [dwf_pkg::HALF_W-1:0]    half_size,
  input  logic [dwf_pkg::COLOUR_W-1:0]  fill_colour,
  output logic                          empty,
  input  logic                          pop,
  output logic [dwf_pkg::BYTE_W-1:0]    out_byte,
  output logic                          is_data,
  output logic                          last
);

  import dwf_pkg::*;

  localparam int WORK_W = $bits(work_t);
  localparam int RES_W  = $bits(res_t);

  logic  q_wr;
  logic  q_rd;
  logic  q_empty;
  work_t q_in;
  work_t q_out;
  logic  out_wr;
  logic  out_full;
  res_t  out_in;
  res_t  out_q;

  // front: config registers and clipping
  dwf_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .cmd        (cmd),
    .centre_x   (centre_x),
    .centre_y   (centre_y),
    .half_size  (half_size),
    .fill_colour(fill_colour),
    .q_full     (full),
    .q_wr       (q_wr),
    .q_data     (q_in)
  );

  // request queue between front and back
  dwf_fifo #(
    .WIDTH(WORK_W),
    .DEPTH(2)
  ) u_req_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_wr),
    .wr_data(q_in),
    .rd_en  (q_rd),
    .rd_data(q_out),
    .full   (full),
    .empty  (q_empty)
  );

  // back: byte sequencer
  dwf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_out),
    .q_rd    (q_rd),
    .out_full(out_full),
    .out_wr  (out_wr),
    .out_data(out_in)
  );

  // result queue
  dwf_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (out_wr),
    .wr_data(out_in),
    .rd_en  (pop),
    .rd_data(out_q),
    .full   (out_full),
    .empty  (empty)
  );

  assign out_byte = out_q.out_byte;
  assign is_data  = out_q.is_data;
  assign last     = out_q.last;

endmodule

// ===== tb/tb_display_window_fill_sequencer.sv =====
`timescale 1ns / 100ps
module tb_display_window_fill_sequencer;
  import dwf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned IDLE_PCT    = 21;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;

  // DCS command bytes and header positions
  localparam logic [BYTE_W-1:0] DCS_COLUMN_SET = 8'h2A;
  localparam logic [BYTE_W-1:0] DCS_ROW_SET    = 8'h2B;
  localparam logic [BYTE_W-1:0] DCS_RAM_WRITE  = 8'h2C;
  localparam int unsigned HDR_COLUMN  = 0;
  localparam int unsigned HDR_ROW     = 5;
  localparam int unsigned HDR_RAM     = 10;
  localparam int unsigned PIXEL_PHASE = 11;

  // register indexes with nothing behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);

  typedef struct packed {
    logic                cmd;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic [HALF_W-1:0]   half;
    logic [COLOUR_W-1:0] colour;
  } fill_req_t;

  // Predicts the byte stream of the window fill and checks it
  class fill_byte_tracker;
    logic [COORD_W-1:0]  col_limit;
    logic [COORD_W-1:0]  row_limit;
    bit                  running;
    int unsigned         hdr_idx;
    logic [COORD_W-1:0]  bounds[4];
    int unsigned         pixels_left;
    logic [COLOUR_W-1:0] colour;
    bit                  low_next;
    res_t                expected_bytes[$];
    int unsigned         mismatches;
    int unsigned         checked;
    int unsigned         fills_done;
    int unsigned         restarts;

    function new();
      col_limit = COLUMN_LIMIT_RESET;
      row_limit = ROW_LIMIT_RESET;
      running = 0;
      hdr_idx = 0;
      foreach (bounds[i]) bounds[i] = '0;
      pixels_left = 0;
      colour = '0;
      low_next = 0;
      mismatches = 0;
      checked = 0;
      fills_done = 0;
      restarts = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
      if (idx == REG_COLUMN_LIMIT) col_limit = val;
      else if (idx == REG_ROW_LIMIT) row_limit = val;
    endfunction

    // clamp the centre, then clip the window to zero and the limit
    function void clip(input int unsigned c, input int unsigned half,
                       input int unsigned lim,
                       output logic [COORD_W-1:0] lo, output logic [COORD_W-1:0] hi);
      int unsigned top;
      if (c > lim) c = lim;
      lo = (c >= half) ? COORD_W'(c - half) : '0;
      top = c + half;
      hi = (top <= lim) ? COORD_W'(top) : COORD_W'(lim);
    endfunction

    function res_t header_byte(int unsigned idx);
      res_t r;
      int unsigned k;
      logic [COORD_W-1:0] b;
      r.is_data = 1'b1;
      r.last = 1'b0;
      case (idx)
        HDR_COLUMN: begin
          r.out_byte = DCS_COLUMN_SET;
          r.is_data = 1'b0;
        end
        HDR_ROW: begin
          r.out_byte = DCS_ROW_SET;
          r.is_data = 1'b0;
        end
        HDR_RAM: begin
          r.out_byte = DCS_RAM_WRITE;
          r.is_data = 1'b0;
        end
        default: begin
          // high byte then low byte of each bound
          k = (idx < HDR_ROW) ? idx - 1 : idx - 6;
          b = bounds[((idx < HDR_ROW) ? 0 : 2) + (k >> 1)];
          r.out_byte = k[0] ? b[7:0] : BYTE_W'(b >> 8);
        end
      endcase
      return r;
    endfunction

    function void note_request(fill_req_t rq);
      res_t r;
      if (rq.cmd == CMD_START) begin
        if (running) restarts++;
        clip(rq.cx, rq.half, col_limit, bounds[0], bounds[1]);
        clip(rq.cy, rq.half, row_limit, bounds[2], bounds[3]);
        pixels_left = (int'(bounds[1]) - int'(bounds[0]) + 1) *
                      (int'(bounds[3]) - int'(bounds[2]) + 1);
        colour = rq.colour;
        hdr_idx = 0;
        low_next = 0;
        running = 1;
      end else if (running) begin
        r.is_data = 1'b1;
        r.last = 1'b0;
        if (hdr_idx < PIXEL_PHASE) begin
          r = header_byte(hdr_idx);
          hdr_idx++;
        end else if (!low_next) begin
          r.out_byte = colour[15:8];
          low_next = 1;
        end else begin
          r.out_byte = colour[7:0];
          low_next = 0;
          if (pixels_left > 0) pixels_left--;
          if (pixels_left == 0) begin
            r.last = 1'b1;
            running = 0;
            hdr_idx = 0;
            fills_done++;
          end
        end
        expected_bytes.push_back(r);
      end
    endfunction

    // advances still needed to finish the running fill
    function int unsigned bytes_left();
      if (!running) return 0;
      return (PIXEL_PHASE - hdr_idx) + 2 * pixels_left - low_next;
    endfunction

    function void check_byte(res_t got);
      res_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("byte %02h data %0d last %0d arrived with nothing expected",
                   got.out_byte, got.is_data, got.last);
        return;
      end
      want = expected_bytes.pop_front();
      checked++;
      if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected byte %02h data %0d last %0d, got %02h data %0d last %0d",
                   want.out_byte, want.is_data, want.last,
                   got.out_byte, got.is_data, got.last);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COORD_W-1:0]   cfg_data;
  logic                 push;
  logic                 full;
  logic                 cmd;
  logic [COORD_W-1:0]   centre_x;
  logic [COORD_W-1:0]   centre_y;
  logic [HALF_W-1:0]    half_size;
  logic [COLOUR_W-1:0]  fill_colour;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 is_data;
  logic                 last;

  logic        hold = 1'b0;
  logic        calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned n_sent = 0;

  fill_byte_tracker tracker = new();

  display_window_fill_sequencer i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .cmd(cmd),
    .centre_x(centre_x),
    .centre_y(centre_y),
    .half_size(half_size),
    .fill_colour(fill_colour),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .is_data(is_data),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: check on each accepted byte, then pick pop for next cycle
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) tracker.check_byte('{out_byte, is_data, last});
      pop <= !hold && (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic fill_req_t mk_start(int unsigned cx, int unsigned cy,
                                         int unsigned half, int unsigned colour);
    fill_req_t rq;
    rq.cmd = CMD_START;
    rq.cx = COORD_W'(cx);
    rq.cy = COORD_W'(cy);
    rq.half = HALF_W'(half);
    rq.colour = COLOUR_W'(colour);
    return rq;
  endfunction

  // advance with random content in the unused fields
  function automatic fill_req_t mk_advance();
    fill_req_t rq;
    rq = mk_start($urandom_range(0, 511), $urandom_range(0, 511),
                  $urandom_range(0, 255), $urandom_range(0, 65535));
    rq.cmd = CMD_ADVANCE;
    return rq;
  endfunction

  // mostly small windows so fills complete; now and then a large one
  function automatic fill_req_t random_start();
    int unsigned r, half;
    r = $urandom_range(99);
    if (r < 70) half = $urandom_range(0, 2);
    else if (r < 90) half = $urandom_range(0, 6);
    else half = $urandom_range(0, 255);
    return mk_start($urandom_range(0, 511), $urandom_range(0, 511), half,
                    $urandom_range(0, 65535));
  endfunction

  // one request; push stays high afterwards so back-to-back requests stream
  task automatic send(input fill_req_t rq);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    cmd <= rq.cmd;
    centre_x <= rq.cx;
    centre_y <= rq.cy;
    half_size <= rq.half;
    fill_colour <= rq.colour;
    do @(posedge clk); while (full);
    tracker.note_request(rq);
    n_sent++;
  endtask

  task automatic advance(int unsigned n);
    repeat (n) send(mk_advance());
  endtask

  // drain all expected bytes, then let requests with no byte pass through
  task automatic quiesce();
    push <= 1'b0;
    while (tracker.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_limit(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(int unsigned col, int unsigned row);
    write_reg(REG_COLUMN_LIMIT, COORD_W'(col));
    write_reg(REG_ROW_LIMIT, COORD_W'(row));
  endtask

  // complete fills, cut-off fills restarted by the next start, stray advances
  task automatic random_fills(int unsigned count);
    int unsigned goal, left, n;
    goal = n_sent + count;
    while (n_sent < goal) begin
      send(random_start());
      left = tracker.bytes_left();
      if ($urandom_range(99) < 75 && left <= 200) begin
        advance(left);
        if ($urandom_range(99) < 10) advance($urandom_range(1, 3));
      end else begin
        n = $urandom_range(0, (left > 40) ? 40 : left - 1);
        advance(n);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    push <= 1'b0;
    cmd <= CMD_START;
    centre_x <= '0;
    centre_y <= '0;
    half_size <= '0;
    fill_colour <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: stray advance, one-pixel fill, clamped huge window, restart
    advance(1);
    send(mk_start(0, 0, 0, 16'hFFFF));
    advance(13);
    send(mk_start(511, 511, 255, 16'h0000));
    advance(4);
    send(mk_start(100, 200, 1, 16'h5AA5));
    advance(2);

    // reset limits
    random_fills(150);

    // zero limits: every window collapses to one pixel
    quiesce();
    set_limits(0, 0);
    random_fills(150);

    // full range; output held off while a large fill backs up the input
    quiesce();
    set_limits(511, 511);
    fork
      begin
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
      end
    join_none
    send(mk_start(256, 256, 255, 16'hC33C));
    advance(120);
    random_fills(130);

    // random limits, unmapped indexes, no idling on either side
    quiesce();
    calm <= 1'b1;
    write_reg(REG_UNMAPPED_LO, COORD_W'($urandom_range(0, 511)));
    set_limits($urandom_range(0, 511), $urandom_range(0, 511));
    write_reg(REG_UNMAPPED_HI, COORD_W'($urandom_range(0, 511)));
    random_fills(150);

    quiesce();
    calm <= 1'b0;
    set_limits($urandom_range(0, 511), $urandom_range(0, 511));
    random_fills(150);

    // lopsided extremes
    quiesce();
    set_limits(511, 0);
    random_fills(150);

    quiesce();
    $display("%0d requests sent, %0d bytes checked, %0d fills completed, %0d restarted mid-fill",
             n_sent, tracker.checked, tracker.fills_done, tracker.restarts);
    $display("limits swept across zero, full range, defaults and random; %0d mismatches",
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.expected_bytes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
